### hdl/dsc_pkg.sv
// Shared types, constants and arithmetic helpers for the distinct substring counter.
// No dependencies; every module of the block imports this package.
package dsc_pkg;

  localparam int MAX_LEN     = 64;
  localparam int TABLE_DEPTH = 4096;

  localparam int BUF_AW  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int RES_W   = 30;
  localparam int KEY_W   = 2 * RES_W;
  localparam int EPOCH_W = 4;
  localparam int WORD_W  = EPOCH_W + KEY_W;
  localparam int MULT_W  = 8;
  localparam int STEP_W  = $clog2(MULT_W);
  localparam int OUT_W   = 12;

  localparam logic [RES_W-1:0]  PRIME_A     = 30'd1000000009;
  localparam logic [RES_W-1:0]  PRIME_B     = 30'd1000000007;
  localparam logic [MULT_W-1:0] HASH_BASE   = 8'd31;
  localparam logic [7:0]        CHAR_OFFSET = 8'd96;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = CNT_W'(4095);

  typedef struct packed {
    logic              start;
    logic [MULT_W-1:0] mult;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RES_W-1:0] res_a;
    logic [RES_W-1:0] res_b;
  } mm_rsp_t;

  // One double-and-add step of a modular multiply, most significant bit first.
  function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0] acc,
                                                input logic [RES_W-1:0] x,
                                                input logic             b,
                                                input logic [RES_W-1:0] p);
    logic [RES_W:0] a;
    a = {acc, 1'b0};
    if (a >= {1'b0, p}) a = a - {1'b0, p};
    if (b) a = a + {1'b0, x};
    if (a >= {1'b0, p}) a = a - {1'b0, p};
    return a[RES_W-1:0];
  endfunction

  function automatic logic [TBL_AW-1:0] key_slot(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = k ^ (k >> 29) ^ (k >> 47);
    return h[TBL_AW-1:0];
  endfunction

endpackage

### hdl/distinct_substring_counter.sv
// Top level of the distinct substring counter: string buffer, sequencer, set logic.
// Depends on dsc_pkg, dsc_modmul and dsc_key_table.
//
//  channel  | direction | ports                                  | transfer
//  ---------+-----------+----------------------------------------+---------------------
//  in       | input     | in_char_code, in_last                  | in_valid & in_ready
//  out      | output    | out_distinct_count, out_overflow       | out_valid & out_ready
//
// A byte that is not last is taken and leaves the block ready for the next. A last byte
// of an L-byte string walks L*(L+1)/2 substrings, each followed by one or more table
// probes; the 8-step shared modular multiplier is used twice per substring.
// After reset, and after every 15th string, a clearing pass rewrites every slot of the
// key table while in_ready is low. The block takes bytes while an earlier result waits
// on out_ready; a finished walk holds until the result register frees.
module distinct_substring_counter
  import dsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char_code,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_distinct_count,
  output logic             out_overflow
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_START = 10'b0000000100,
    S_RD    = 10'b0000001000,
    S_MULA  = 10'b0000010000,
    S_WMUL  = 10'b0000100000,
    S_WPOW  = 10'b0001000000,
    S_CMP   = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt, start_r, start_nxt, pos_r, pos_nxt;
  logic [RES_W-1:0]   hash_a_r, hash_a_nxt, hash_b_r, hash_b_nxt;
  logic [RES_W-1:0]   pow_a_r, pow_a_nxt, pow_b_r, pow_b_nxt;
  logic               neg_r, neg_nxt;
  logic               too_long_r, too_long_nxt, full_r, full_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [TBL_AW-1:0]  clr_addr_r, clr_addr_nxt, slot_r, slot_nxt, probe_r, probe_nxt;
  logic               out_valid_r, out_valid_nxt, ovf_r, ovf_nxt;
  logic [OUT_W-1:0]   dcount_r, dcount_nxt;

  logic [7:0]         text_buffer [MAX_LEN];
  logic [7:0]         buf_q_r;
  logic               buf_wr, buf_rd;

  mm_req_t            mm_req;
  mm_rsp_t            mm_rsp;
  logic [RES_W-1:0]   mm_xa, mm_xb;

  logic               kt_rd_en, kt_wr_en;
  logic [TBL_AW-1:0]  kt_rd_addr, kt_wr_addr;
  logic [WORD_W-1:0]  kt_rd_data, kt_wr_data;
  logic [KEY_W-1:0]   key;
  logic               in_xfer, out_free;

  // Adds or subtracts a product into a running hash, modulo p.
  function automatic logic [RES_W-1:0] mod_acc(input logic [RES_W-1:0] h,
                                               input logic [RES_W-1:0] t,
                                               input logic             neg,
                                               input logic [RES_W-1:0] p);
    logic [RES_W:0] s;
    if (neg) begin
      if (h >= t) s = {1'b0, h} - {1'b0, t};
      else        s = {1'b0, h} + {1'b0, p} - {1'b0, t};
    end else begin
      s = {1'b0, h} + {1'b0, t};
      if (s >= {1'b0, p}) s = s - {1'b0, p};
    end
    return s[RES_W-1:0];
  endfunction

  dsc_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .x_a   (mm_xa),
    .x_b   (mm_xb),
    .rsp   (mm_rsp)
  );

  dsc_key_table u_key_table (
    .clk     (clk),
    .rd_en   (kt_rd_en),
    .rd_addr (kt_rd_addr),
    .rd_data (kt_rd_data),
    .wr_en   (kt_wr_en),
    .wr_addr (kt_wr_addr),
    .wr_data (kt_wr_data)
  );

  assign key      = {hash_a_r, hash_b_r};
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign buf_wr   = in_xfer && (len_r < LEN_W'(MAX_LEN));
  assign buf_rd   = (state_r == S_RD);
  assign mm_xa    = pow_a_r;
  assign mm_xb    = pow_b_r;

  always_ff @(posedge clk) begin
    if (buf_wr) text_buffer[len_r[BUF_AW-1:0]] <= in_char_code;
    if (buf_rd) buf_q_r <= text_buffer[pos_r[BUF_AW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    hash_a_nxt    = hash_a_r;
    hash_b_nxt    = hash_b_r;
    pow_a_nxt     = pow_a_r;
    pow_b_nxt     = pow_b_r;
    neg_nxt       = neg_r;
    too_long_nxt  = too_long_r;
    full_nxt      = full_r;
    count_nxt     = count_r;
    epoch_nxt     = epoch_r;
    clr_addr_nxt  = clr_addr_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ovf_nxt       = ovf_r;
    dcount_nxt    = dcount_r;
    mm_req.start  = 1'b0;
    mm_req.mult   = HASH_BASE;
    kt_rd_en      = 1'b0;
    kt_rd_addr    = slot_r;
    kt_wr_en      = 1'b0;
    kt_wr_addr    = slot_r;
    kt_wr_data    = {epoch_r, key};

    unique case (state_r)
      S_CLEAR: begin
        // Epoch zero marks a slot that no string has used since the pass.
        kt_wr_en     = 1'b1;
        kt_wr_addr   = clr_addr_r;
        kt_wr_data   = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == TBL_AW'(TABLE_DEPTH - 1)) begin
          clr_addr_nxt = '0;
          epoch_nxt    = EPOCH_W'(1);
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (buf_wr) len_nxt = len_r + 1'b1;
          else        too_long_nxt = 1'b1;
          if (in_last) begin
            start_nxt = '0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        hash_a_nxt = '0;
        hash_b_nxt = '0;
        pow_a_nxt  = RES_W'(1);
        pow_b_nxt  = RES_W'(1);
        pos_nxt    = start_r;
        state_nxt  = S_RD;
      end
      S_RD: begin
        state_nxt = S_MULA;
      end
      S_MULA: begin
        // The character value is byte minus the offset; a negative one is handled
        // by multiplying its magnitude and subtracting.
        mm_req.start = 1'b1;
        if (buf_q_r >= CHAR_OFFSET) begin
          mm_req.mult = buf_q_r - CHAR_OFFSET;
          neg_nxt     = 1'b0;
        end else begin
          mm_req.mult = CHAR_OFFSET - buf_q_r;
          neg_nxt     = 1'b1;
        end
        state_nxt = S_WMUL;
      end
      S_WMUL: begin
        if (mm_rsp.done) begin
          hash_a_nxt   = mod_acc(hash_a_r, mm_rsp.res_a, neg_r, PRIME_A);
          hash_b_nxt   = mod_acc(hash_b_r, mm_rsp.res_b, neg_r, PRIME_B);
          mm_req.start = 1'b1;
          mm_req.mult  = HASH_BASE;
          state_nxt    = S_WPOW;
        end
      end
      S_WPOW: begin
        if (mm_rsp.done) begin
          pow_a_nxt  = mm_rsp.res_a;
          pow_b_nxt  = mm_rsp.res_b;
          kt_rd_en   = 1'b1;
          kt_rd_addr = key_slot(key);
          slot_nxt   = key_slot(key);
          probe_nxt  = '0;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        if (kt_rd_data[WORD_W-1:KEY_W] != epoch_r) begin
          kt_wr_en  = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = S_NEXT;
        end else if (kt_rd_data[KEY_W-1:0] == key) begin
          state_nxt = S_NEXT;
        end else if (probe_r == TBL_AW'(TABLE_DEPTH - 1)) begin
          full_nxt  = 1'b1;
          state_nxt = S_NEXT;
        end else begin
          slot_nxt   = (slot_r == TBL_AW'(TABLE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          probe_nxt  = probe_r + 1'b1;
          kt_rd_en   = 1'b1;
          kt_rd_addr = slot_nxt;
        end
      end
      S_NEXT: begin
        if ((pos_r + 1'b1) < len_r) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_RD;
        end else if ((start_r + 1'b1) < len_r) begin
          start_nxt = start_r + 1'b1;
          state_nxt = S_START;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r > COUNT_MAX) begin
            dcount_nxt = COUNT_MAX[OUT_W-1:0];
            ovf_nxt    = 1'b1;
          end else begin
            dcount_nxt = count_r[OUT_W-1:0];
            ovf_nxt    = too_long_r || full_r;
          end
          len_nxt      = '0;
          count_nxt    = '0;
          too_long_nxt = 1'b0;
          full_nxt     = 1'b0;
          hash_a_nxt   = '0;
          hash_b_nxt   = '0;
          pow_a_nxt    = RES_W'(1);
          pow_b_nxt    = RES_W'(1);
          // Running out of epoch tags forces a fresh clearing pass.
          if (epoch_r == {EPOCH_W{1'b1}}) begin
            state_nxt = S_CLEAR;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      len_r       <= '0;
      start_r     <= '0;
      pos_r       <= '0;
      hash_a_r    <= '0;
      hash_b_r    <= '0;
      pow_a_r     <= RES_W'(1);
      pow_b_r     <= RES_W'(1);
      neg_r       <= 1'b0;
      too_long_r  <= 1'b0;
      full_r      <= 1'b0;
      count_r     <= '0;
      epoch_r     <= '0;
      clr_addr_r  <= '0;
      slot_r      <= '0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      start_r     <= start_nxt;
      pos_r       <= pos_nxt;
      hash_a_r    <= hash_a_nxt;
      hash_b_r    <= hash_b_nxt;
      pow_a_r     <= pow_a_nxt;
      pow_b_r     <= pow_b_nxt;
      neg_r       <= neg_nxt;
      too_long_r  <= too_long_nxt;
      full_r      <= full_nxt;
      count_r     <= count_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
      slot_r      <= slot_nxt;
      probe_r     <= probe_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r    <= ovf_nxt;
    dcount_r <= dcount_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_distinct_count = dcount_r;
  assign out_overflow       = ovf_r;

  a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    hash_a_r < PRIME_A && hash_b_r < PRIME_B)
    else $error("running hash left its residue range");

  a_pow_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    pow_a_r < PRIME_A && pow_b_r < PRIME_B)
    else $error("running power left its residue range");

  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mm_rsp.busy)
    else $error("multiplier busy while bytes are taken");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (len_r == '0 && count_r == '0 && out_valid_r))
    else $error("string state not cleared after a result");

endmodule

### hdl/dsc_modmul.sv
// Shared modular multiplier: two lanes, one per prime, bit-serial over the multiplier.
// Depends on dsc_pkg.
module dsc_modmul
  import dsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mm_req_t          req,
  input  logic [RES_W-1:0] x_a,
  input  logic [RES_W-1:0] x_b,
  output mm_rsp_t          rsp
);

  logic [RES_W-1:0]  acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  logic [RES_W-1:0]  xa_r, xb_r;
  logic [MULT_W-1:0] m_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;

  assign acc_a_nxt = mod_step(acc_a_r, xa_r, m_r[MULT_W-1], PRIME_A);
  assign acc_b_nxt = mod_step(acc_b_r, xb_r, m_r[MULT_W-1], PRIME_B);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MULT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
      xa_r    <= x_a;
      xb_r    <= x_b;
      m_r     <= req.mult;
    end else if (busy_r) begin
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      m_r     <= {m_r[MULT_W-2:0], 1'b0};
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.res_a = acc_a_r;
  assign rsp.res_b = acc_b_r;

endmodule

### hdl/dsc_key_table.sv
// Key set storage: one word per slot holding an epoch tag and the 60-bit hash pair.
// Depends on dsc_pkg. One write port, one read port with registered data.
module dsc_key_table
  import dsc_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [TBL_AW-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [TBL_AW-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
